// ----- src/efcs_pkg.sv -----
// Shared types, constants and the frame classification function.
`timescale 1ns / 1ps
package efcs_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 1518;
  localparam int unsigned NUM_COUNTERS    = 19;
  localparam int unsigned DIV_STEPS       = 48;

  // Statistic selectors
  localparam logic [4:0] STAT_MIN = 5'd19;
  localparam logic [4:0] STAT_MAX = 5'd20;
  localparam logic [4:0] STAT_AVG = 5'd21;

  // Counter indexes
  localparam int unsigned CNT_FRAMES    = 0;
  localparam int unsigned CNT_IPV4      = 1;
  localparam int unsigned CNT_IPV6      = 2;
  localparam int unsigned CNT_ARP       = 3;
  localparam int unsigned CNT_ARP_REQ   = 4;
  localparam int unsigned CNT_ARP_REP   = 5;
  localparam int unsigned CNT_TCP       = 6;
  localparam int unsigned CNT_UDP       = 7;
  localparam int unsigned CNT_ICMP      = 8;
  localparam int unsigned CNT_ICMP_REQ  = 9;
  localparam int unsigned CNT_ICMP_REP  = 10;
  localparam int unsigned CNT_ICMP6     = 11;
  localparam int unsigned CNT_ICMP6_REQ = 12;
  localparam int unsigned CNT_ICMP6_REP = 13;
  localparam int unsigned CNT_HTTP      = 14;
  localparam int unsigned CNT_DHCP      = 15;
  localparam int unsigned CNT_DNS       = 16;
  localparam int unsigned CNT_HTTPS     = 17;
  localparam int unsigned CNT_OTHER_APP = 18;

  // EtherTypes, protocols and ports
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [15:0] ETH_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  PROTO_ICMP6 = 8'd58;
  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_DHCP  = 16'd68;
  localparam logic [15:0] PORT_DNS   = 16'd53;
  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [15:0] ARP_OP_REQ = 16'd1;
  localparam logic [15:0] ARP_OP_REP = 16'd2;
  localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
  localparam logic [7:0]  ICMP_ECHO_REP  = 8'd0;
  localparam logic [7:0]  ICMP6_ECHO_REQ = 8'd128;
  localparam logic [7:0]  ICMP6_ECHO_REP = 8'd129;

  // Header byte positions
  localparam logic [10:0] POS_ET_HI    = 11'd12;
  localparam logic [10:0] POS_ET_LO    = 11'd13;
  localparam logic [10:0] POS_L3       = 11'd14;
  localparam logic [10:0] POS_W0_HI    = 11'd20;
  localparam logic [10:0] POS_W0_LO    = 11'd21;
  localparam logic [10:0] POS_V4_PROTO = 11'd23;
  localparam logic [10:0] POS_V4_ICMP  = 11'd34;
  localparam logic [10:0] POS_V6_L4    = 11'd54;

  localparam logic [10:0] MAX_LEN    = 11'(MAX_FRAME_BYTES);
  localparam logic [10:0] MIN_RESET  = 11'h7FF;

  typedef enum logic [1:0] {
    LINK_OTHER = 2'd0, LINK_IPV4 = 2'd1, LINK_IPV6 = 2'd2, LINK_ARP = 2'd3
  } link_t;

  typedef enum logic [2:0] {
    TR_NONE = 3'd0, TR_TCP = 3'd1, TR_UDP = 3'd2, TR_ICMP = 3'd3,
    TR_ICMP6 = 3'd4, TR_UNKNOWN = 3'd5
  } trans_t;

  typedef enum logic [1:0] {
    MSG_NONE = 2'd0, MSG_REQ = 2'd1, MSG_REP = 2'd2
  } msg_t;

  typedef enum logic [2:0] {
    APP_NONE = 3'd0, APP_HTTP = 3'd1, APP_DHCP = 3'd2, APP_DNS = 3'd3,
    APP_HTTPS = 3'd4, APP_OTHER = 3'd5
  } app_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CLASS, S_COUNT, S_FETCH, S_DIVIDE, S_HOLD
  } state_t;

  // Captured header fields of the frame in progress
  typedef struct packed {
    logic [10:0] pos;
    logic [15:0] et;
    logic [15:0] hw0;
    logic [15:0] hw1;
    logic [15:0] hw2;
    logic [7:0]  tb1;
    logic [7:0]  tb2;
    logic [7:0]  tb3;
  } cap_t;

  typedef struct packed {
    link_t                    link;
    trans_t                   trans;
    msg_t                     msg;
    app_t                     app;
    logic [15:0]              sp;
    logic [15:0]              dp;
    logic [NUM_COUNTERS-1:0]  mask;
  } cls_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  link_class;
    logic [2:0]  transport_class;
    logic [1:0]  message_kind;
    logic [2:0]  app_class;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [10:0] frame_length;
    logic [31:0] read_value;
  } res_t;

  function automatic logic port_hit(logic [15:0] s, logic [15:0] d, logic [15:0] p);
    return (s == p) || (d == p);
  endfunction

  // Classify a finished frame and flag the counters it bumps
  function automatic cls_t classify(cap_t c);
    cls_t r;
    logic ip;
    logic [7:0] proto;
    r = '0;
    r.link = LINK_OTHER;
    r.trans = TR_NONE;
    r.msg = MSG_NONE;
    r.app = APP_NONE;
    ip = 1'b0;
    proto = '0;
    r.mask[CNT_FRAMES] = 1'b1;
    if (c.et == ETH_IPV4) begin
      r.link = LINK_IPV4; r.mask[CNT_IPV4] = 1'b1; ip = 1'b1; proto = c.tb1;
    end else if (c.et == ETH_IPV6) begin
      r.link = LINK_IPV6; r.mask[CNT_IPV6] = 1'b1; ip = 1'b1; proto = c.hw0[15:8];
    end else if (c.et == ETH_ARP) begin
      r.link = LINK_ARP; r.mask[CNT_ARP] = 1'b1;
      if (c.hw0 == ARP_OP_REP) begin
        r.msg = MSG_REP; r.mask[CNT_ARP_REP] = 1'b1;
      end else if (c.hw0 == ARP_OP_REQ) begin
        r.msg = MSG_REQ; r.mask[CNT_ARP_REQ] = 1'b1;
      end
    end
    if (ip) begin
      if (proto == PROTO_TCP) begin
        r.trans = TR_TCP; r.mask[CNT_TCP] = 1'b1;
      end else if (proto == PROTO_UDP) begin
        r.trans = TR_UDP; r.mask[CNT_UDP] = 1'b1;
      end else if (proto == PROTO_ICMP) begin
        r.trans = TR_ICMP; r.mask[CNT_ICMP] = 1'b1;
        if (c.tb2 == ICMP_ECHO_REQ) begin
          r.msg = MSG_REQ; r.mask[CNT_ICMP_REQ] = 1'b1;
        end else if (c.tb2 == ICMP_ECHO_REP) begin
          r.msg = MSG_REP; r.mask[CNT_ICMP_REP] = 1'b1;
        end
      end else if (proto == PROTO_ICMP6) begin
        r.trans = TR_ICMP6; r.mask[CNT_ICMP6] = 1'b1;
        if (c.tb3 == ICMP6_ECHO_REQ) begin
          r.msg = MSG_REQ; r.mask[CNT_ICMP6_REQ] = 1'b1;
        end else if (c.tb3 == ICMP6_ECHO_REP) begin
          r.msg = MSG_REP; r.mask[CNT_ICMP6_REP] = 1'b1;
        end
      end else begin
        r.trans = TR_UNKNOWN;
      end
      if (r.trans == TR_TCP || r.trans == TR_UDP) begin
        r.sp = c.hw1;
        r.dp = c.hw2;
        if (port_hit(c.hw1, c.hw2, PORT_HTTP)) begin
          r.app = APP_HTTP; r.mask[CNT_HTTP] = 1'b1;
        end else if (port_hit(c.hw1, c.hw2, PORT_DHCP)) begin
          r.app = APP_DHCP; r.mask[CNT_DHCP] = 1'b1;
        end else if (port_hit(c.hw1, c.hw2, PORT_DNS)) begin
          r.app = APP_DNS; r.mask[CNT_DNS] = 1'b1;
        end else if (port_hit(c.hw1, c.hw2, PORT_HTTPS)) begin
          r.app = APP_HTTPS; r.mask[CNT_HTTPS] = 1'b1;
        end else begin
          r.app = APP_OTHER; r.mask[CNT_OTHER_APP] = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- src/efcs_in_if.sv -----
// Input channel: frame bytes and statistic reads.
`timescale 1ns / 1ps
interface efcs_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [4:0] stat_index;

  modport source(output valid, action, data_byte, last_byte, stat_index, input ready);
  modport sink(input valid, action, data_byte, last_byte, stat_index, output ready);
endinterface

// ----- src/efcs_out_if.sv -----
// Output channel: classification results and statistic values.
`timescale 1ns / 1ps
interface efcs_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  link_class;
  logic [2:0]  transport_class;
  logic [1:0]  message_kind;
  logic [2:0]  app_class;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [10:0] frame_length;
  logic [31:0] read_value;

  modport source(output valid, result_kind, link_class, transport_class, message_kind,
                 app_class, source_port, dest_port, frame_length, read_value,
                 input ready);
  modport sink(input valid, result_kind, link_class, transport_class, message_kind,
               app_class, source_port, dest_port, frame_length, read_value,
               output ready);
endinterface

// ----- src/ethernet_frame_classifier_stats.sv -----
// Top level: sequencer, shared counter incrementer, length statistics, output register.
//
//   channel  | dir | beat carries
//   ---------+-----+------------------------------------------------------
//   items    | in  | action, data_byte, last_byte, stat_index
//   results  | out | result_kind, link/transport/message/app class, ports,
//            |     | frame_length, read_value
//
// A non-final frame byte is only captured and the sequencer stays idle. A final
// byte is accepted, classified in S_CLASS, then the shared incrementer walks all
// 19 counters in the counter store in S_COUNT, and S_HOLD loads the output.
// Counter, minimum and maximum reads go through S_FETCH to S_HOLD; an average
// read with a nonzero frame count also runs the bit-serial divider in S_DIVIDE.
// rst is synchronous; counters read as zero after it. items.ready is low while
// a beat is in work or a result waits for a full output register.
`timescale 1ns / 1ps
module ethernet_frame_classifier_stats
  import efcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  efcs_in_if.sink  items,
  efcs_out_if.source results
);

  state_t      state, state_next;
  cap_t        cap;
  cls_t        cls;
  res_t        pend, out_reg;
  logic        out_valid;
  logic [4:0]  cnt_idx;
  logic [4:0]  rd_idx;
  logic [10:0] shortest, longest;
  logic [47:0] len_sum;
  logic [4:0]  raddr;
  logic [31:0] rdata;
  logic        we;
  logic [4:0]  waddr;
  logic        accept;
  logic        byte_take;
  logic        cap_clear;
  logic        div_start;
  logic        div_done;
  logic [31:0] quotient;
  logic        load_out;

  assign accept    = items.valid && items.ready;
  assign byte_take = accept && !items.action;
  assign load_out  = (state == S_HOLD) && (!out_valid || results.ready);

  efcs_capture u_capture (
    .clk(clk), .rst(rst), .take(byte_take), .data_byte(items.data_byte),
    .clear(cap_clear), .cap(cap)
  );

  efcs_counter_ram u_counters (
    .clk(clk), .rst(rst), .raddr(raddr), .rdata(rdata),
    .we(we), .waddr(waddr), .wdata(rdata + 32'd1)
  );

  efcs_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(len_sum), .divisor(rdata),
    .done(div_done), .quotient(quotient)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (items.action) state_next = S_FETCH;
          else if (items.last_byte) state_next = S_CLASS;
        end
      end
      S_CLASS:  state_next = S_COUNT;
      S_COUNT:  if (cnt_idx == 5'(NUM_COUNTERS)) state_next = S_HOLD;
      S_FETCH: begin
        if (rd_idx == STAT_AVG && rdata != 32'd0) state_next = S_DIVIDE;
        else state_next = S_HOLD;
      end
      S_DIVIDE: if (div_done) state_next = S_HOLD;
      S_HOLD:   if (load_out) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    items.ready = 1'b0;
    cap_clear   = 1'b0;
    div_start   = 1'b0;
    we          = 1'b0;
    waddr       = cnt_idx - 5'd1;
    raddr       = 5'd0;
    case (state)
      S_IDLE: begin
        items.ready = 1'b1;
        // start the read at the accepting edge; the average needs the frame count
        if (items.stat_index < 5'(NUM_COUNTERS)) raddr = items.stat_index;
      end
      S_CLASS: cap_clear = 1'b1;
      S_COUNT: begin
        if (cnt_idx < 5'(NUM_COUNTERS)) raddr = cnt_idx;
        if (cnt_idx != 5'd0) we = cls.mask[waddr];
      end
      S_FETCH: div_start = (rd_idx == STAT_AVG) && (rdata != 32'd0);
      default: ;
    endcase
  end

  // Sequencer and statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      shortest <= MIN_RESET;
      longest  <= '0;
      len_sum  <= '0;
      cnt_idx  <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CLASS: cnt_idx <= '0;
        S_COUNT: begin
          cnt_idx <= cnt_idx + 5'd1;
          if (cnt_idx == 5'(NUM_COUNTERS)) begin
            if (pend.frame_length < shortest) shortest <= pend.frame_length;
            if (pend.frame_length > longest) longest <= pend.frame_length;
            len_sum <= len_sum + {37'd0, pend.frame_length};
          end
        end
        default: ;
      endcase
    end
  end

  // Payload of the pending result
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) rd_idx <= items.stat_index;
    case (state)
      S_CLASS: begin
        cls <= classify(cap);
        pend.result_kind     <= 1'b0;
        pend.link_class      <= classify(cap).link;
        pend.transport_class <= classify(cap).trans;
        pend.message_kind    <= classify(cap).msg;
        pend.app_class       <= classify(cap).app;
        pend.source_port     <= classify(cap).sp;
        pend.dest_port       <= classify(cap).dp;
        pend.frame_length    <= cap.pos;
        pend.read_value      <= '0;
      end
      S_FETCH: begin
        pend.result_kind     <= 1'b1;
        pend.link_class      <= LINK_OTHER;
        pend.transport_class <= TR_NONE;
        pend.message_kind    <= MSG_NONE;
        pend.app_class       <= APP_NONE;
        pend.source_port     <= '0;
        pend.dest_port       <= '0;
        pend.frame_length    <= '0;
        if (rd_idx < 5'(NUM_COUNTERS)) pend.read_value <= rdata;
        else if (rd_idx == STAT_MIN) pend.read_value <= {21'd0, shortest};
        else if (rd_idx == STAT_MAX) pend.read_value <= {21'd0, longest};
        else pend.read_value <= '0;
      end
      S_DIVIDE: if (div_done) pend.read_value <= quotient;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_reg <= pend;
  end

  assign results.valid           = out_valid;
  assign results.result_kind     = out_reg.result_kind;
  assign results.link_class      = out_reg.link_class;
  assign results.transport_class = out_reg.transport_class;
  assign results.message_kind    = out_reg.message_kind;
  assign results.app_class       = out_reg.app_class;
  assign results.source_port     = out_reg.source_port;
  assign results.dest_port       = out_reg.dest_port;
  assign results.frame_length    = out_reg.frame_length;
  assign results.read_value      = out_reg.read_value;

endmodule

// ----- src/efcs_capture.sv -----
// Header byte capture for the frame in progress.
`timescale 1ns / 1ps
module efcs_capture
  import efcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       clear,
  output cap_t       cap
);

  cap_t       c;
  logic [7:0] tb0;
  logic [3:0] ihl;
  logic [10:0] base;

  // IPv4 port offset from IHL, using the byte just arriving at position 14
  assign ihl  = (c.pos == POS_L3) ? data_byte[3:0] : tb0[3:0];
  assign base = POS_L3 + {5'd0, ihl, 2'b00};

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      c   <= '0;
      tb0 <= '0;
    end else if (take && (c.pos < MAX_LEN)) begin
      c.pos <= c.pos + 11'd1;
      if (c.pos == POS_ET_HI) c.et[15:8] <= data_byte;
      if (c.pos == POS_ET_LO) c.et[7:0] <= data_byte;
      if (c.pos == POS_L3) tb0 <= data_byte;
      if (c.pos == POS_W0_HI) c.hw0[15:8] <= data_byte;
      if (c.pos == POS_W0_LO) c.hw0[7:0] <= data_byte;
      if (c.pos == POS_V4_PROTO) c.tb1 <= data_byte;
      if (c.pos == POS_V4_ICMP) c.tb2 <= data_byte;
      if (c.pos == POS_V6_L4) c.tb3 <= data_byte;
      if (c.pos >= POS_L3) begin
        if (c.et == ETH_IPV4) begin
          if (c.pos == base) c.hw1[15:8] <= data_byte;
          if (c.pos == base + 11'd1) c.hw1[7:0] <= data_byte;
          if (c.pos == base + 11'd2) c.hw2[15:8] <= data_byte;
          if (c.pos == base + 11'd3) c.hw2[7:0] <= data_byte;
        end else if (c.et == ETH_IPV6) begin
          if (c.pos == POS_V6_L4) c.hw1[15:8] <= data_byte;
          if (c.pos == POS_V6_L4 + 11'd1) c.hw1[7:0] <= data_byte;
          if (c.pos == POS_V6_L4 + 11'd2) c.hw2[15:8] <= data_byte;
          if (c.pos == POS_V6_L4 + 11'd3) c.hw2[7:0] <= data_byte;
        end
      end
    end
  end

  assign cap = c;

endmodule

// ----- src/efcs_counter_ram.sv -----
// Event counter store: one write port, one registered read port, valid bits.
`timescale 1ns / 1ps
module efcs_counter_ram
  import efcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  raddr,
  output logic [31:0] rdata,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [31:0] wdata
);

  logic [31:0]             mem [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] valid;
  logic [31:0]             rword;
  logic                    rvalid;

  // Storage
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rword <= mem[raddr];
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (we) valid[waddr] <= 1'b1;
      rvalid <= valid[raddr];
    end
  end

  assign rdata = rvalid ? rword : 32'd0;

endmodule

// ----- src/efcs_divider.sv -----
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
`timescale 1ns / 1ps
module efcs_divider
  import efcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [47:0] q;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [5:0]  step;
  logic        busy;
  logic [32:0] rem_sh;
  logic [33:0] diff;

  // One shift-subtract step
  assign rem_sh = {rem[31:0], q[47]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[33]) begin
        rem <= diff[32:0];
        q   <= {q[46:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[46:0], 1'b0};
      end
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 6'd1;
        if (step == 6'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = (q[47:32] != 16'd0) ? 32'hFFFF_FFFF : q[31:0];

endmodule
